@@ rtl/wdfp_pkg.sv @@
// Package for the WLAN data frame parser: payload structs, phase codes, status codes.
// No dependencies.
package wdfp_pkg;

    localparam int ADDR_BYTES_DEF = 6;
    localparam logic [5:0] HDR_BASE = 6'd24;
    localparam logic [15:0] SUBHDR_LEN = 16'd14;
    localparam logic [15:0] LLC_LEN = 16'd8;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [15:0] frame_len;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  status;
        logic [15:0] ethertype;
        logic [15:0] payload_offset;
        logic [15:0] payload_len;
        logic [47:0] src_mac;
        logic [47:0] dst_mac;
        logic        is_last;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HDR, PH_SUBHDR, PH_LLC, PH_BODY, PH_PAD, PH_SKIP
    } phase_t;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_NOT_DATA    = 4'd1;
    localparam logic [3:0] ST_NO_DATA     = 4'd2;
    localparam logic [3:0] ST_PROTECTED   = 4'd3;
    localparam logic [3:0] ST_TRUNC_HDR   = 4'd4;
    localparam logic [3:0] ST_TRUNC_SUBHDR = 4'd5;
    localparam logic [3:0] ST_TRUNC_AMSDU = 4'd6;
    localparam logic [3:0] ST_BAD_INNER   = 4'd7;
    localparam logic [3:0] ST_TRUNC_LLC   = 4'd8;
    localparam logic [3:0] ST_NOT_SNAP    = 4'd9;

    function automatic logic [7:0] snap_byte(input logic [2:0] idx);
        case (idx)
            3'd0: snap_byte = 8'hAA;
            3'd1: snap_byte = 8'hAA;
            3'd2: snap_byte = 8'h03;
            default: snap_byte = 8'h00;
        endcase
    endfunction

endpackage

@@ rtl/wdfp_out_queue.sv @@
// Four-entry result queue between the parser core and the output channel.
// Depends on wdfp_pkg.
module wdfp_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr0,
    input  wdfp_pkg::out_item_t d0,
    input  logic                wr1,
    input  wdfp_pkg::out_item_t d1,
    output logic                empty,
    output logic                out_valid,
    output wdfp_pkg::out_item_t out_data,
    input  logic                out_stall
);
    import wdfp_pkg::*;

    out_item_t   mem_reg [4];
    logic [1:0]  rd_reg, wr_reg;
    logic [2:0]  cnt_reg;
    logic        pop;
    logic [2:0]  push_n;

    assign out_valid = cnt_reg != 3'd0;
    assign out_data  = mem_reg[rd_reg];
    assign empty     = cnt_reg == 3'd0;
    assign pop       = out_valid && !out_stall;
    assign push_n    = {2'd0, wr0} + {2'd0, wr1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (pop)
                rd_reg <= rd_reg + 2'd1;
            wr_reg  <= wr_reg + push_n[1:0];
            cnt_reg <= cnt_reg + push_n - {2'd0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr0)
            mem_reg[wr_reg] <= d0;
        if (wr1)
            mem_reg[wr0 ? wr_reg + 2'd1 : wr_reg] <= d1;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4) else $error("result queue overflow");
    a_valid_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid == (cnt_reg != 3'd0)) else $error("valid mismatch");
    a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !wr0 && !wr1) |=> cnt_reg == $past(cnt_reg) - 3'd1)
        else $error("pop count");

endmodule

@@ rtl/wlan_data_frame_parser.sv @@
// Top level of the WLAN data frame parser: input register, parse core, result queue.
// Depends on wdfp_pkg and wdfp_out_queue.
//
//  channel | ports                     | payload
//  in      | in_valid, in_stall        | in_data  (in_item_t)
//  out     | out_valid, out_stall      | out_data (out_item_t)
//
// One byte per cycle while in_stall is low; each byte's results appear in the queue the cycle after transfer.
// A byte yields at most two results (inner packet and frame status).
// The four-entry queue sets the rate: input stalls when fewer than two slots are free.
// Reset clears the phase and queue pointers; no clearing pass.
module wlan_data_frame_parser #(
    parameter int ADDR_BYTES = wdfp_pkg::ADDR_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  wdfp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output wdfp_pkg::out_item_t out_data
);
    import wdfp_pkg::*;

    localparam logic [5:0] ADDR_LEN = 6'(ADDR_BYTES);

    phase_t      phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next, tot_reg, tot_next, rem_reg, rem_next, shift_reg, shift_next;
    logic [7:0]  fc_lo_reg, fc_lo_next;
    logic [1:0]  ds_reg, ds_next, pad_reg, pad_next;
    logic [5:0]  hlen_reg, hlen_next;
    logic        amsdu_reg, amsdu_next;
    logic [47:0] src_reg, src_next, dst_reg, dst_next;
    logic [3:0]  fidx_reg, fidx_next, fst_reg, fst_next;
    logic        wr0, wr1;
    out_item_t   r0, r1;
    logic        accept, q_empty;
    logic [1:0]  q_used;

    wdfp_out_queue u_q (
        .clk(clk), .rst_n(rst_n), .wr0(wr0), .d0(r0), .wr1(wr1), .d1(r1),
        .empty(q_empty), .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
    );

    // stall unless queue has room for two results
    logic [2:0] occ_reg, occ_next;
    assign in_stall = occ_reg > 3'd2;
    assign accept   = in_valid && !in_stall;
    assign q_used   = 2'(occ_reg);

    always_comb
    begin
        occ_next = occ_reg + {2'd0, wr0} + {2'd0, wr1}
                 - {2'd0, out_valid && !out_stall};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            occ_reg   <= '0;
            pos_reg   <= '0;
            tot_reg   <= '0;
            rem_reg   <= '0;
            shift_reg <= '0;
            fc_lo_reg <= '0;
            ds_reg    <= '0;
            pad_reg   <= '0;
            hlen_reg  <= HDR_BASE;
            amsdu_reg <= 1'b0;
            src_reg   <= '0;
            dst_reg   <= '0;
            fidx_reg  <= '0;
            fst_reg   <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                tot_reg   <= tot_next;
                rem_reg   <= rem_next;
                shift_reg <= shift_next;
                fc_lo_reg <= fc_lo_next;
                ds_reg    <= ds_next;
                pad_reg   <= pad_next;
                hlen_reg  <= hlen_next;
                amsdu_reg <= amsdu_next;
                src_reg   <= src_next;
                dst_reg   <= dst_next;
                fidx_reg  <= fidx_next;
                fst_reg   <= fst_next;
            end
        end
    end

    logic [15:0] pos, np, tl, left, h16;
    logic [7:0]  b;
    logic        go, sub_ok;
    logic [5:0]  hdr;
    logic [1:0]  ds;
    logic [2:0]  slot;
    logic [15:0] sh, l;
    logic [15:0] rs;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        tot_next   = tot_reg;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        fc_lo_next = fc_lo_reg;
        ds_next    = ds_reg;
        pad_next   = pad_reg;
        hlen_next  = hlen_reg;
        amsdu_next = amsdu_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        fidx_next  = fidx_reg;
        fst_next   = fst_reg;
        wr0 = 1'b0;
        wr1 = 1'b0;
        r0  = '0;
        r1  = '0;
        b   = in_data.data_byte;
        go  = 1'b1;
        hdr = HDR_BASE;
        slot = 3'd0;
        sh  = '0;
        l   = '0;
        rs  = '0;
        sub_ok = 1'b0;
        h16 = '0;
        tl  = tot_reg;
        pos = pos_reg;
        np  = pos_reg + 16'd1;
        left = '0;
        ds  = ds_reg;

        if (in_data.first_byte)
        begin
            tl = (in_data.frame_len == 16'd0) ? 16'd1 : in_data.frame_len;
            tot_next   = tl;
            pos        = '0;
            np         = 16'd1;
            phase_next = PH_HDR;
            fc_lo_next = '0;
            ds_next    = '0;
            ds         = '0;
            pad_next   = '0;
            hlen_next  = HDR_BASE;
            amsdu_next = 1'b0;
            src_next   = '0;
            dst_next   = '0;
            fidx_next  = '0;
            shift_next = '0;
            rem_next   = '0;
            fst_next   = ST_OK;
            if (tl <= 16'd24)
            begin
                fst_next   = ST_TRUNC_HDR;
                phase_next = PH_SKIP;
            end
        end
        else if (phase_reg == PH_IDLE)
        begin
            go = 1'b0;
        end
        left = tl - np;

        if (go)
        begin
            case (phase_next)
                PH_HDR:
                begin
                    if (pos == 16'd0)
                    begin
                        fc_lo_next = b;
                        if (!b[3])
                        begin
                            fst_next = ST_NOT_DATA;
                            phase_next = PH_SKIP;
                        end
                        else if (b[6])
                        begin
                            fst_next = ST_NO_DATA;
                            phase_next = PH_SKIP;
                        end
                    end
                    else if (pos == 16'd1)
                    begin
                        ds_next = b[1:0];
                        hdr = HDR_BASE + ((b[1:0] == 2'd3) ? ADDR_LEN : 6'd0);
                        if ({10'd0, hdr} >= tl)
                        begin
                            fst_next = ST_TRUNC_HDR;
                            phase_next = PH_SKIP;
                        end
                        else if (fc_lo_reg[7] && b[6])
                        begin
                            fst_next = ST_PROTECTED;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            if (fc_lo_reg[7])
                                hdr = hdr + 6'd2;
                            if ({10'd0, hdr} >= tl)
                            begin
                                fst_next = ST_TRUNC_HDR;
                                phase_next = PH_SKIP;
                            end
                            else
                                hlen_next = hdr;
                        end
                    end
                    if (phase_next == PH_HDR)
                    begin
                        if (pos >= 16'd4 && pos < 16'd10) slot = 3'd1;
                        else if (pos >= 16'd10 && pos < 16'd16) slot = 3'd2;
                        else if (pos >= 16'd16 && pos < 16'd22) slot = 3'd3;
                        else if (ds == 2'd3 && pos >= 16'd24
                                 && pos < 16'd24 + {10'd0, ADDR_LEN}) slot = 3'd4;
                        if ((ds <= 2'd1 && slot == 3'd2) || (ds == 2'd2 && slot == 3'd3)
                            || (ds == 2'd3 && slot == 3'd4))
                            src_next = {src_reg[39:0], b};
                        if (((ds == 2'd0 || ds == 2'd2) && slot == 3'd1)
                            || ((ds == 2'd1 || ds == 2'd3) && slot == 3'd3))
                            dst_next = {dst_reg[39:0], b};
                        h16 = {10'd0, hlen_next};
                        if (fc_lo_reg[7] && pos >= 16'd2 && pos == h16 - 16'd2)
                            amsdu_next = b[7];
                        if (pos >= 16'd1 && pos == h16 - 16'd1)
                        begin
                            if (amsdu_next)
                            begin
                                if (left == 16'd0) phase_next = PH_SKIP;
                                else if (left < SUBHDR_LEN)
                                begin
                                    fst_next = ST_TRUNC_SUBHDR;
                                    phase_next = PH_SKIP;
                                end
                                else
                                begin
                                    phase_next = PH_SUBHDR;
                                    fidx_next = '0;
                                    shift_next = '0;
                                end
                            end
                            else if (left < LLC_LEN)
                            begin
                                fst_next = ST_TRUNC_LLC;
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                rem_next = left;
                                fidx_next = '0;
                                shift_next = '0;
                                phase_next = PH_LLC;
                            end
                        end
                    end
                end
                PH_SUBHDR:
                begin
                    sh = (fidx_reg >= 4'd12) ? {shift_reg[7:0], b} : shift_reg;
                    shift_next = sh;
                    if (fidx_reg == 4'd13)
                    begin
                        l = sh;
                        if (left < l)
                        begin
                            fst_next = ST_TRUNC_AMSDU;
                            phase_next = PH_SKIP;
                        end
                        else if (l < LLC_LEN)
                        begin
                            fst_next = ST_BAD_INNER;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            rem_next = l;
                            pad_next = 2'd2 - l[1:0];
                            fidx_next = '0;
                            shift_next = '0;
                            phase_next = PH_LLC;
                        end
                    end
                    else
                        fidx_next = fidx_reg + 4'd1;
                end
                PH_LLC:
                begin
                    rs = rem_reg - 16'd1;
                    rem_next = rs;
                    if (fidx_reg < 4'd6 && b != snap_byte(fidx_reg[2:0]))
                    begin
                        fst_next = amsdu_reg ? ST_BAD_INNER : ST_NOT_SNAP;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        sh = (fidx_reg >= 4'd6) ? {shift_reg[7:0], b} : shift_reg;
                        shift_next = sh;
                        if (fidx_reg == 4'd7)
                        begin
                            wr0 = 1'b1;
                            r0.ethertype = sh;
                            r0.payload_offset = np;
                            r0.payload_len = rs;
                            r0.src_mac = src_reg;
                            r0.dst_mac = dst_reg;
                            if (rs != 16'd0) phase_next = PH_BODY;
                            else sub_ok = 1'b1;
                        end
                        else
                            fidx_next = fidx_reg + 4'd1;
                    end
                end
                PH_BODY:
                begin
                    rs = rem_reg - 16'd1;
                    rem_next = rs;
                    if (rs == 16'd0) sub_ok = 1'b1;
                end
                PH_PAD:
                begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_next == 2'd0)
                    begin
                        if (left == 16'd0) phase_next = PH_SKIP;
                        else if (left < SUBHDR_LEN)
                        begin
                            fst_next = ST_TRUNC_SUBHDR;
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            phase_next = PH_SUBHDR;
                            fidx_next = '0;
                            shift_next = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (sub_ok)
            begin
                if (!amsdu_reg || left == 16'd0) phase_next = PH_SKIP;
                else if (left >= {14'd0, pad_reg})
                begin
                    if (pad_reg != 2'd0) phase_next = PH_PAD;
                    else if (left < SUBHDR_LEN)
                    begin
                        fst_next = ST_TRUNC_SUBHDR;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_SUBHDR;
                        fidx_next = '0;
                        shift_next = '0;
                    end
                end
                else
                begin
                    fst_next = ST_TRUNC_SUBHDR;
                    phase_next = PH_SKIP;
                end
            end

            if (np >= tl || pos == 16'hFFFF)
            begin
                r1.kind = 1'b1;
                r1.status = fst_next;
                r1.is_last = 1'b1;
                phase_next = PH_IDLE;
                if (wr0) wr1 = 1'b1;
                else
                begin
                    wr0 = 1'b1;
                    r0 = r1;
                end
            end
            else
                pos_next = np;
        end
        if (!accept)
        begin
            wr0 = 1'b0;
            wr1 = 1'b0;
        end
    end

    a_occ_track: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty == (occ_reg == 3'd0)) else $error("occupancy mismatch");
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> q_used <= 2'd2) else $error("accept without room");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && wr0 && r0.is_last) |=> phase_reg == PH_IDLE)
        else $error("status without idle");

endmodule

@@ test/wlan_data_frame_parser_tb.sv @@
// Testbench for wlan_data_frame_parser: directed and random 802.11 frames, byte by byte,
// with a scoreboard that predicts the inner-packet and end-of-frame results.
// Depends on wdfp_pkg and the parser RTL.
module wlan_data_frame_parser_tb;
    import wdfp_pkg::*;

    localparam int NADDR = 6;

    class frame_scoreboard;
        out_item_t expq[$];
        int errors;
        int inner_seen;
        int status_seen;
        int status_hits[16];
        int pos_r;
        int tot;
        phase_t ph;
        logic [15:0] fc;
        int hdr_len;
        bit amsdu;
        logic [47:0] src;
        logic [47:0] dst;
        logic [15:0] sub_rem;
        int fidx;
        logic [15:0] shift;
        logic [3:0] fstat;
        logic [1:0] pad;
        logic [7:0] snap_ref[6] = '{8'hAA, 8'hAA, 8'h03, 8'h00, 8'h00, 8'h00};

        function void clear();
            pos_r = 0;
            tot = 0;
            ph = PH_IDLE;
            fc = '0;
            hdr_len = 24;
            amsdu = 0;
            src = '0;
            dst = '0;
            sub_rem = '0;
            fidx = 0;
            shift = '0;
            fstat = ST_OK;
            pad = '0;
        endfunction

        function new();
            clear();
        endfunction

        function void stop(logic [3:0] st);
            fstat = st;
            ph = PH_SKIP;
        endfunction

        function void start_sub(int np);
            int rem;
            rem = tot - np;
            if (rem == 0)
                ph = PH_SKIP;
            else if (rem < 14)
                stop(ST_TRUNC_SUBHDR);
            else
            begin
                ph = PH_SUBHDR;
                fidx = 0;
                shift = '0;
            end
        endfunction

        function void after_inner(int np);
            int rem;
            rem = tot - np;
            if (!amsdu || rem == 0)
                ph = PH_SKIP;
            else if (rem >= pad)
            begin
                if (pad == 0)
                    start_sub(np);
                else
                    ph = PH_PAD;
            end
            else
                stop(ST_TRUNC_SUBHDR);
        endfunction

        function void enter_body(int np);
            int l;
            l = tot - np;
            if (amsdu)
                start_sub(np);
            else if (l < 8)
                stop(ST_TRUNC_LLC);
            else
            begin
                sub_rem = 16'(l);
                fidx = 0;
                shift = '0;
                ph = PH_LLC;
            end
        endfunction

        function void header_byte(int pos, logic [7:0] b);
            int ds;
            int slot;
            int hdr;
            bit to_src;
            bit to_dst;
            ds = fc[9:8];
            slot = -1;
            if (pos == 0)
            begin
                fc = {8'h00, b};
                if (!b[3])
                begin
                    stop(ST_NOT_DATA);
                    return;
                end
                if (b[6])
                begin
                    stop(ST_NO_DATA);
                    return;
                end
            end
            else if (pos == 1)
            begin
                hdr = 24;
                fc[15:8] = b;
                if (b[1:0] == 2'b11)
                    hdr += NADDR;
                if (hdr >= tot)
                begin
                    stop(ST_TRUNC_HDR);
                    return;
                end
                if (fc[7])
                begin
                    if (b[6])
                    begin
                        stop(ST_PROTECTED);
                        return;
                    end
                    hdr += 2;
                    if (hdr >= tot)
                    begin
                        stop(ST_TRUNC_HDR);
                        return;
                    end
                end
                hdr_len = hdr;
            end
            if (pos >= 4 && pos < 10)
                slot = 1;
            else if (pos >= 10 && pos < 16)
                slot = 2;
            else if (pos >= 16 && pos < 22)
                slot = 3;
            else if (ds == 3 && pos >= 24 && pos < 24 + NADDR)
                slot = 4;
            if (slot > 0)
            begin
                to_src = (ds <= 1 && slot == 2) || (ds == 2 && slot == 3) ||
                         (ds == 3 && slot == 4);
                to_dst = ((ds == 0 || ds == 2) && slot == 1) ||
                         ((ds == 1 || ds == 3) && slot == 3);
                if (to_src)
                    src = {src[39:0], b};
                if (to_dst)
                    dst = {dst[39:0], b};
            end
            if (fc[7] && pos >= 2 && pos == hdr_len - 2)
                amsdu = b[7];
            if (pos >= 1 && pos == hdr_len - 1)
                enter_body(pos + 1);
        endfunction

        function void note_input(in_item_t it);
            int pos;
            out_item_t r;
            logic [7:0] b;
            b = it.data_byte;
            if (it.first_byte)
            begin
                clear();
                tot = (it.frame_len == 0) ? 1 : it.frame_len;
                ph = PH_HDR;
                if (tot <= 24)
                    stop(ST_TRUNC_HDR);
            end
            else if (ph == PH_IDLE)
                return;
            pos = pos_r;
            case (ph)
                PH_HDR: header_byte(pos, b);
                PH_SUBHDR:
                begin
                    if (fidx >= 12)
                        shift = {shift[7:0], b};
                    if (fidx == 13)
                    begin
                        if (tot - (pos + 1) < shift)
                            stop(ST_TRUNC_AMSDU);
                        else if (shift < 8)
                            stop(ST_BAD_INNER);
                        else
                        begin
                            sub_rem = shift;
                            pad = 2'(2 - shift);
                            fidx = 0;
                            shift = '0;
                            ph = PH_LLC;
                        end
                    end
                    else
                        fidx++;
                end
                PH_LLC:
                begin
                    sub_rem = sub_rem - 16'd1;
                    if (fidx < 6 && b != snap_ref[fidx])
                        stop(amsdu ? ST_BAD_INNER : ST_NOT_SNAP);
                    else
                    begin
                        if (fidx >= 6)
                            shift = {shift[7:0], b};
                        if (fidx == 7)
                        begin
                            r = '0;
                            r.ethertype = shift;
                            r.payload_offset = 16'(pos + 1);
                            r.payload_len = sub_rem;
                            r.src_mac = src;
                            r.dst_mac = dst;
                            expq.push_back(r);
                            if (sub_rem > 0)
                                ph = PH_BODY;
                            else
                                after_inner(pos + 1);
                        end
                        else
                            fidx++;
                    end
                end
                PH_BODY:
                begin
                    sub_rem = sub_rem - 16'd1;
                    if (sub_rem == 0)
                        after_inner(pos + 1);
                end
                PH_PAD:
                begin
                    pad = pad - 2'd1;
                    if (pad == 0)
                        start_sub(pos + 1);
                end
                default: ;
            endcase
            if (pos + 1 >= tot)
            begin
                r = '0;
                r.kind = 1'b1;
                r.status = fstat;
                r.is_last = 1'b1;
                expq.push_back(r);
                ph = PH_IDLE;
            end
            else
                pos_r = pos + 1;
        endfunction

        function void check(out_item_t got);
            out_item_t e;
            if (expq.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: %h", got);
                return;
            end
            e = expq.pop_front();
            if (got.kind !== e.kind || got.status !== e.status ||
                got.ethertype !== e.ethertype || got.payload_offset !== e.payload_offset ||
                got.payload_len !== e.payload_len || got.src_mac !== e.src_mac ||
                got.dst_mac !== e.dst_mac || got.is_last !== e.is_last)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("mismatch: exp kind %0d st %0d et %h off %0d len %0d",
                             e.kind, e.status, e.ethertype, e.payload_offset,
                             e.payload_len);
                    $display("          exp src %h dst %h last %0d",
                             e.src_mac, e.dst_mac, e.is_last);
                    $display("          got kind %0d st %0d et %h off %0d len %0d",
                             got.kind, got.status, got.ethertype, got.payload_offset,
                             got.payload_len);
                    $display("          got src %h dst %h last %0d",
                             got.src_mac, got.dst_mac, got.is_last);
                end
            end
            if (e.kind)
            begin
                status_seen++;
                status_hits[e.status]++;
            end
            else
                inner_seen++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;

    frame_scoreboard sb;
    logic [7:0] frame_q[$];
    int tx_pct;
    int rx_pct;
    bit hold_go;
    int bytes_sent;
    int frames_sent;

    wlan_data_frame_parser dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    // receiver: random stall, with one long hold on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go = 0;
                repeat (300)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
            end
            out_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check(out_data);

    task automatic push_item(logic [7:0] b, bit first, logic [15:0] len);
        in_item_t it;
        it.data_byte = b;
        it.first_byte = first;
        it.frame_len = len;
        while ($urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(it);
        bytes_sent++;
        @(negedge clk);
    endtask

    // build a frame into frame_q (well-formed unless short_first); returns the header length
    function automatic int build_frame(int ds, bit qos, bit agg, int nsub, bit short_first);
        int hdr;
        int l;
        logic [7:0] b0;
        b0 = 8'h08 | (8'($urandom) & 8'h37) | (qos ? 8'h80 : 8'h00);
        frame_q.delete();
        frame_q.push_back(b0);
        frame_q.push_back(8'(ds) | (8'($urandom) & 8'hBC));
        repeat (22)
            frame_q.push_back(8'($urandom));
        hdr = 24;
        if (ds == 3)
        begin
            repeat (NADDR)
                frame_q.push_back(8'($urandom));
            hdr += NADDR;
        end
        if (qos)
        begin
            frame_q.push_back({agg, 7'($urandom)});
            frame_q.push_back(8'($urandom));
            hdr += 2;
        end
        if (!(qos && agg))
            nsub = 1;
        for (int s = 0; s < nsub; s++)
        begin
            l = (short_first && s == 0) ? $urandom_range(7) : 8 + $urandom_range(4);
            if (qos && agg)
            begin
                repeat (12)
                    frame_q.push_back(8'($urandom));
                frame_q.push_back(8'(l >> 8));
                frame_q.push_back(8'(l));
            end
            if (l >= 8)
            begin
                frame_q.push_back(8'hAA);
                frame_q.push_back(8'hAA);
                frame_q.push_back(8'h03);
                repeat (3)
                    frame_q.push_back(8'h00);
                repeat (l - 6)
                    frame_q.push_back(8'($urandom));
            end
            else
                repeat (l)
                    frame_q.push_back(8'($urandom));
            if (qos && agg && s < nsub - 1)
                repeat ((2 - l) & 3)
                    frame_q.push_back(8'($urandom));
        end
        return hdr;
    endfunction

    // send count bytes of frame_q (random beyond its end), announcing length len;
    // the idle phase advances every six frames
    task automatic send_frame(logic [15:0] len, int count);
        frames_sent++;
        case ((frames_sent / 6) % 4)
            0:
            begin
                tx_pct = 0;
                rx_pct = 0;
            end
            1:
            begin
                tx_pct = 75;
                rx_pct = 0;
            end
            2:
            begin
                tx_pct = 0;
                rx_pct = 75;
            end
            default:
            begin
                tx_pct = 21;
                rx_pct = 21;
            end
        endcase
        if (frames_sent == 13)
            hold_go = 1;
        for (int i = 0; i < count; i++)
            push_item(i < frame_q.size() ? frame_q[i] : 8'($urandom), i == 0, len);
    endtask

    task automatic send_whole(int len);
        send_frame(16'(len), (len == 0) ? 1 : len);
    endtask

    task automatic drain(int limit);
        int n;
        n = 0;
        while (sb.expq.size() != 0 && n < limit)
        begin
            @(negedge clk);
            n++;
        end
    endtask

    initial
    begin
        int hdr;
        int len;
        int pick;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        tx_pct = 0;
        rx_pct = 0;
        hold_go = 0;
        bytes_sent = 0;
        frames_sent = 0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stray bytes outside any frame are dropped
        push_item(8'hFF, 1'b0, 16'hFFFF);
        push_item(8'h00, 1'b0, 16'h0000);
        // not a data frame, null subtype, protected QoS
        hdr = build_frame(0, 1, 0, 1, 0);
        frame_q[0][3] = 1'b0;
        send_whole(frame_q.size());
        hdr = build_frame(1, 0, 0, 1, 0);
        frame_q[0][6] = 1'b1;
        send_whole(frame_q.size());
        hdr = build_frame(2, 1, 1, 2, 0);
        frame_q[1][6] = 1'b1;
        send_whole(frame_q.size());
        // zero length and short headers
        send_whole(0);
        hdr = build_frame(0, 0, 0, 1, 0);
        send_whole(24);
        send_whole(25);
        hdr = build_frame(3, 1, 0, 1, 0);
        send_whole(31);
        send_whole(32);
        // one MSDU per DS setting, QoS and not
        for (int d = 0; d < 4; d++)
        begin
            hdr = build_frame(d, d[0], 0, 1, 0);
            send_whole(frame_q.size());
        end
        // short MSDU, missing SNAP
        hdr = build_frame(1, 1, 0, 1, 0);
        send_whole(hdr + 5);
        frame_q[hdr + 2] = 8'h04;
        send_whole(frame_q.size());
        // A-MSDU: clean chain, bad inner, truncated subframe, short padding, short subheader
        hdr = build_frame(3, 1, 1, 3, 0);
        send_whole(frame_q.size());
        hdr = build_frame(2, 1, 1, 2, 1);
        send_whole(frame_q.size());
        hdr = build_frame(0, 1, 1, 2, 0);
        send_whole(hdr + 20);
        for (int k = 1; k <= 3; k++)
        begin
            hdr = build_frame(1, 1, 1, 2, 0);
            send_whole(hdr + 14 + ((frame_q[hdr + 12] << 8) | frame_q[hdr + 13]) + k);
        end
        hdr = build_frame(0, 1, 1, 1, 0);
        frame_q[hdr + 6] = 8'h00;
        send_whole(frame_q.size());
        // a maximum-length frame abandoned by a new frame
        hdr = build_frame(0, 1, 0, 1, 0);
        send_frame(16'hFFFF, 40);
        send_whole(frame_q.size());
        drain(5000);

        // random frames with random damage
        do
        begin
            hdr = build_frame($urandom_range(3), $urandom_range(3) != 0, $urandom_range(2) != 0,
                              1 + $urandom_range(3), $urandom_range(9) == 0);
            len = frame_q.size();
            pick = $urandom_range(99);
            if (pick < 8)
                len = 1 + $urandom_range(len - 1);
            else if (pick < 14)
                frame_q[hdr + $urandom_range(len - hdr - 1)] = 8'($urandom);
            else if (pick < 18)
                len = len + 1 + $urandom_range(6);
            else if (pick < 20)
                frame_q[0] = 8'($urandom);
            if (pick >= 20 && pick < 23)
                send_frame(16'(len), $urandom_range(len - 1));
            else
                send_whole(len);
            if ($urandom_range(19) == 0)
                push_item(8'($urandom), 1'b0, 16'($urandom));
        end
        while (bytes_sent < 900);
        in_valid <= 1'b0;
        drain(200000);
        repeat (20)
            @(negedge clk);
        if (sb.expq.size() != 0)
            sb.errors++;
        $display("%0d frames, %0d bytes; %0d inner packets, %0d status results, %0d errors",
                 frames_sent, bytes_sent, sb.inner_seen, sb.status_seen, sb.errors);
        $display("status counts ok %0d, trunc hdr %0d, trunc amsdu %0d, bad inner %0d",
                 sb.status_hits[ST_OK], sb.status_hits[ST_TRUNC_HDR],
                 sb.status_hits[ST_TRUNC_AMSDU], sb.status_hits[ST_BAD_INNER]);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
